// ===== rtl/clps_pkg.sv =====
package clps_pkg;

   // Fixed field widths
   localparam int OP_W   = 3;
   localparam int PIDX_W = 13;
   localparam int CFG_W  = 13;
   localparam int NUM_W  = 16;
   localparam int HDR_W  = 2 * NUM_W;

   // Working page numbers: wide enough for any store depth plus the look-ahead of three
   localparam int PAGE_W = 17;

   localparam int unsigned MAX_PAGES_DEF = 4096;

   localparam logic [CFG_W-1:0] NUM_PAGES_RST = CFG_W'(4096);
   localparam logic [NUM_W-1:0] ERASED_NUM    = '1;
   localparam logic [HDR_W-1:0] ERASED_HDR    = '1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD      = 3'd0;
   localparam logic [OP_W-1:0] OP_LAST_PAGE = 3'd1;
   localparam logic [OP_W-1:0] OP_LAST_MSG  = 3'd2;
   localparam logic [OP_W-1:0] OP_MSG_COUNT = 3'd3;
   localparam logic [OP_W-1:0] OP_MSG_PAGE  = 3'd4;

   // Sequencer to header store
   typedef struct packed {
      logic              wr_en;
      logic [PAGE_W-1:0] wr_page;
      logic [HDR_W-1:0]  wr_data;
      logic              rd_en;
      logic [PAGE_W-1:0] rd_page;
   } store_cmd_type;

endpackage

// ===== rtl/circular_log_page_search.sv =====
// Items: load and the unused codes answer without a search; last page runs a bisection;
// last message adds a header read, message count up to two header reads; the last page of a
// message runs a second bisection. Throughput: one item at a time, the next can be taken in
// the cycle in which rsp_valid rises; a bisection step is a header read state (S_LOOP_RD)
// and a compare state (S_LOOP_WT).
// Reset: synchronous; num_pages returns to 4096; no item taken until the store is erased.
module circular_log_page_search #(
   parameter int unsigned MAX_PAGES = clps_pkg::MAX_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [clps_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [clps_pkg::OP_W-1:0]    req_operation,
   input  logic [clps_pkg::PIDX_W-1:0]  req_page_index,
   input  logic [clps_pkg::NUM_W-1:0]   req_file_number,
   input  logic [clps_pkg::NUM_W-1:0]   req_file_page,
   input  logic [clps_pkg::NUM_W-1:0]   req_msg_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [clps_pkg::NUM_W-1:0]   rsp_answer
);
   import clps_pkg::*;

   logic [CFG_W-1:0] num_pages_ff;
   store_cmd_type    cmd;
   logic [HDR_W-1:0] rd_data;
   logic             store_busy;

   // Page count register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_pages_ff <= NUM_PAGES_RST;
      end else if (csr_wr_en) begin
         num_pages_ff <= csr_wr_data;
      end
   end

   clps_seq #(
      .MAX_PAGES (MAX_PAGES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .num_pages       (num_pages_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_page_index  (req_page_index),
      .req_file_number (req_file_number),
      .req_file_page   (req_file_page),
      .req_msg_number  (req_msg_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_answer      (rsp_answer),
      .cmd             (cmd),
      .rd_data         (rd_data),
      .store_busy      (store_busy)
   );

   clps_store #(
      .MAX_PAGES (MAX_PAGES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   // No item taken while the erase sweep runs
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_ready)
      else $error("item accepted during erase sweep");

   // No header access from the sequencer during the sweep
   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> (!cmd.rd_en && !cmd.wr_en))
      else $error("store access during erase sweep");

   // Loads and reads never share a cycle
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("read and write in the same cycle");

   // One item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while busy");

endmodule

// ===== rtl/clps_store.sv =====
module clps_store #(
   parameter int unsigned MAX_PAGES = clps_pkg::MAX_PAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  clps_pkg::store_cmd_type     cmd,
   output logic [clps_pkg::HDR_W-1:0]  rd_data,
   output logic                        busy
);
   import clps_pkg::*;

   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

   logic [HDR_W-1:0] mem [MAX_PAGES];
   logic [HDR_W-1:0] rd_data_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic             busy_ff;
   logic [PAGE_W-1:0] wr_idx;
   logic [PAGE_W-1:0] rd_idx;

   // Pages count from one, entries from zero
   assign wr_idx = cmd.wr_page - PAGE_W'(1);
   assign rd_idx = cmd.rd_page - PAGE_W'(1);

   // Erase sweep after reset, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_PAGES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= ERASED_HDR;
      end else if (cmd.wr_en) begin
         mem[wr_idx[AW-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ===== rtl/clps_seq.sv =====
module clps_seq #(
   parameter int unsigned MAX_PAGES = clps_pkg::MAX_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [clps_pkg::CFG_W-1:0]   num_pages,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [clps_pkg::OP_W-1:0]    req_operation,
   input  logic [clps_pkg::PIDX_W-1:0]  req_page_index,
   input  logic [clps_pkg::NUM_W-1:0]   req_file_number,
   input  logic [clps_pkg::NUM_W-1:0]   req_file_page,
   input  logic [clps_pkg::NUM_W-1:0]   req_msg_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [clps_pkg::NUM_W-1:0]   rsp_answer,
   output clps_pkg::store_cmd_type      cmd,
   input  logic [clps_pkg::HDR_W-1:0]   rd_data,
   input  logic                         store_busy
);
   import clps_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_H1_RD, S_H1_WT, S_LOOP_RD, S_LOOP_WT, S_LPF_WT,
      S_LAST_RD, S_LAST_WT, S_FIRST_RD, S_FIRST_WT, S_NLAST_RD, S_NLAST_WT,
      S_MTOP_WT, S_MBOT_RD, S_MBOT_WT
   } state_type;

   // Searching, or holding the answer until the output register is free
   typedef enum logic {
      Q_RUN, Q_RESULT
   } phase_type;

   state_type         state_ff;
   phase_type         phase_ff;
   logic [OP_W-1:0]   op_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [NUM_W-1:0]  fnum_ff;
   logic [NUM_W-1:0]  fpg_ff;
   logic [NUM_W-1:0]  msg_ff;
   logic [PAGE_W-1:0] n_ff;
   logic [PAGE_W-1:0] top_ff;
   logic [PAGE_W-1:0] bot_ff;
   logic [PAGE_W-1:0] look_ff;
   logic [PAGE_W-1:0] lp_ff;
   logic [HDR_W-1:0]  bkey_ff;
   logic [NUM_W-1:0]  num1_ff;
   logic [NUM_W-1:0]  last_ff;
   logic [NUM_W-1:0]  ans_ff;
   logic              msg_mode_ff;
   logic              oob_ff;
   logic              rsp_valid_ff;
   logic [NUM_W-1:0]  rsp_answer_ff;

   logic [PAGE_W-1:0] np_w;
   logic [PAGE_W-1:0] n_w;
   logic [PAGE_W:0]   sum_w;
   logic [PAGE_W-1:0] look_w;
   logic              step_go;
   logic [HDR_W-1:0]  hdr_w;
   logic [NUM_W-1:0]  num_w;
   logic [HDR_W-1:0]  key_w;
   logic [PAGE_W-1:0] lp_w;
   logic [HDR_W-1:0]  target_w;
   logic [NUM_W-1:0]  first_w;
   logic              load_ok;

   // Effective page count: zero acts as one, clamp to store depth
   assign np_w = PAGE_W'(num_pages);
   always_comb begin
      if (num_pages == '0) begin
         n_w = PAGE_W'(1);
      end else if (np_w > PAGE_W'(MAX_PAGES)) begin
         n_w = PAGE_W'(MAX_PAGES);
      end else begin
         n_w = np_w;
      end
   end

   // Bisection step
   assign sum_w   = {1'b0, top_ff} + {1'b0, bot_ff};
   assign look_w  = sum_w[PAGE_W:1];
   assign step_go = {1'b0, top_ff} > ({1'b0, bot_ff} + (PAGE_W + 1)'(1));

   // Returned header; pages outside the log read as erased
   assign hdr_w    = oob_ff ? ERASED_HDR : rd_data;
   assign num_w    = hdr_w[HDR_W-1:NUM_W];
   assign key_w    = (num_w == ERASED_NUM) ? '0 : hdr_w;
   assign lp_w     = (key_w > bkey_ff) ? top_ff : bot_ff;
   assign target_w = {msg_ff, ERASED_NUM};
   assign first_w  = (num_w > last_ff) ? num1_ff : num_w;
   assign load_ok  = (pidx_ff != '0) && (PAGE_W'(pidx_ff) <= PAGE_W'(MAX_PAGES));

   // Store commands
   always_comb begin
      cmd         = '0;
      cmd.wr_page = PAGE_W'(pidx_ff);
      cmd.wr_data = {fnum_ff, fpg_ff};
      if (phase_ff == Q_RUN) begin
         case (state_ff)
            S_LOAD: cmd.wr_en = load_ok;
            S_H1_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = PAGE_W'(1);
            end
            S_LOOP_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = step_go ? look_w : top_ff;
            end
            S_LAST_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = lp_ff;
            end
            S_FIRST_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = lp_ff + PAGE_W'(3);
            end
            S_NLAST_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = n_ff;
            end
            S_MBOT_RD: begin
               cmd.rd_en   = 1'b1;
               cmd.rd_page = bot_ff;
            end
            default: cmd.rd_en = 1'b0;
         endcase
      end
   end

   assign req_ready  = (phase_ff == Q_RUN) && (state_ff == S_IDLE) && !store_busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= Q_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         oob_ff <= (cmd.rd_page == '0) || (cmd.rd_page > n_ff);

         if (phase_ff == Q_RESULT) begin
            // Output register free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_ff  <= 1'b1;
               rsp_answer_ff <= ans_ff;
               phase_ff      <= Q_RUN;
               state_ff      <= S_IDLE;
            end
         end else begin
            // Output register emptied
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
            case (state_ff)
               S_IDLE: begin
                  if (req_valid && req_ready) begin
                     op_ff   <= req_operation;
                     pidx_ff <= req_page_index;
                     fnum_ff <= req_file_number;
                     fpg_ff  <= req_file_page;
                     msg_ff  <= req_msg_number;
                     n_ff    <= n_w;
                     ans_ff  <= '0;
                     case (req_operation)
                        OP_LOAD:      state_ff <= S_LOAD;
                        OP_LAST_PAGE,
                        OP_LAST_MSG,
                        OP_MSG_COUNT,
                        OP_MSG_PAGE:  state_ff <= S_H1_RD;
                        default:      phase_ff <= Q_RESULT;
                     endcase
                  end
               end
               S_LOAD: phase_ff <= Q_RESULT;
               S_H1_RD: state_ff <= S_H1_WT;
               S_H1_WT: begin
                  // page 1 key starts unclamped
                  num1_ff     <= num_w;
                  bkey_ff     <= hdr_w;
                  bot_ff      <= PAGE_W'(1);
                  top_ff      <= n_ff;
                  msg_mode_ff <= 1'b0;
                  state_ff    <= S_LOOP_RD;
               end
               S_LOOP_RD: begin
                  if (step_go) begin
                     look_ff  <= look_w;
                     state_ff <= S_LOOP_WT;
                  end else begin
                     state_ff <= msg_mode_ff ? S_MTOP_WT : S_LPF_WT;
                  end
               end
               S_LOOP_WT: begin
                  if (!msg_mode_ff) begin
                     if (key_w < bkey_ff) begin
                        top_ff <= look_ff;
                     end else begin
                        bot_ff  <= look_ff;
                        bkey_ff <= key_w;
                     end
                  end else if (key_w > target_w) begin
                     top_ff <= look_ff;
                  end else begin
                     bot_ff <= look_ff;
                  end
                  state_ff <= S_LOOP_RD;
               end
               S_LPF_WT: begin
                  lp_ff <= lp_w;
                  case (op_ff)
                     OP_LAST_PAGE: begin
                        ans_ff   <= lp_w[NUM_W-1:0];
                        phase_ff <= Q_RESULT;
                     end
                     OP_LAST_MSG: state_ff <= S_LAST_RD;
                     OP_MSG_COUNT: begin
                        if (lp_w == PAGE_W'(1) || num1_ff == ERASED_NUM) begin
                           phase_ff <= Q_RESULT;
                        end else begin
                           state_ff <= S_LAST_RD;
                        end
                     end
                     OP_MSG_PAGE: state_ff <= S_NLAST_RD;
                     default: phase_ff <= Q_RESULT;
                  endcase
               end
               S_LAST_RD: state_ff <= S_LAST_WT;
               S_LAST_WT: begin
                  if (op_ff == OP_LAST_MSG) begin
                     ans_ff   <= num_w;
                     phase_ff <= Q_RESULT;
                  end else begin
                     last_ff  <= num_w;
                     state_ff <= S_FIRST_RD;
                  end
               end
               S_FIRST_RD: state_ff <= S_FIRST_WT;
               S_FIRST_WT: begin
                  // count wraps at 16 bits
                  ans_ff   <= last_ff - first_w + NUM_W'(1);
                  phase_ff <= Q_RESULT;
               end
               S_NLAST_RD: state_ff <= S_NLAST_WT;
               S_NLAST_WT: begin
                  // log wrapped and message older than page 1: search the tail
                  if (num_w != ERASED_NUM && num1_ff > msg_ff) begin
                     bot_ff <= lp_ff;
                     top_ff <= n_ff;
                  end else begin
                     bot_ff <= PAGE_W'(1);
                     top_ff <= lp_ff;
                  end
                  msg_mode_ff <= 1'b1;
                  state_ff    <= S_LOOP_RD;
               end
               S_MTOP_WT: begin
                  if (num_w == msg_ff) begin
                     ans_ff   <= top_ff[NUM_W-1:0];
                     phase_ff <= Q_RESULT;
                  end else begin
                     state_ff <= S_MBOT_RD;
                  end
               end
               S_MBOT_RD: state_ff <= S_MBOT_WT;
               S_MBOT_WT: begin
                  ans_ff   <= (num_w == msg_ff) ? bot_ff[NUM_W-1:0] : ERASED_NUM;
                  phase_ff <= Q_RESULT;
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/circular_log_page_search_tb.sv =====
module circular_log_page_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clps_pkg::*;

   // Codes the block decodes as no-ops
   localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned ITEM_TARGET   = 720;
   localparam int unsigned STALL_LIMIT   = 20000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned FLUSH_CYCLES  = 100;
   localparam int unsigned CFG_MAX       = (1 << CFG_W) - 1;
   localparam int unsigned SMALL_LOG     = 64;

   // Header store mirror and queue of answers still owed by the block
   class page_search_board;
      logic [HDR_W-1:0] hdr_store [MAX_PAGES_DEF];
      int unsigned      page_count;
      logic [NUM_W-1:0] expected_answers [$];
      int unsigned      mismatches;

      function new();
         foreach (hdr_store[i]) hdr_store[i] = ERASED_HDR;
         page_count = int'(NUM_PAGES_RST);
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_answers.size();
      endfunction

      // 0 behaves as 1, anything over the store depth as the full store
      function int unsigned pages_in_use();
         if (page_count == 0) return 1;
         if (page_count > MAX_PAGES_DEF) return MAX_PAGES_DEF;
         return page_count;
      endfunction

      // Pages outside 1..pages_in_use read as erased flash
      function logic [HDR_W-1:0] read_hdr(int unsigned page);
         if (page == 0 || page > pages_in_use()) return ERASED_HDR;
         return hdr_store[page - 1];
      endfunction

      function logic [NUM_W-1:0] read_num(int unsigned page);
         logic [HDR_W-1:0] hdr;
         hdr = read_hdr(page);
         return hdr[HDR_W-1:NUM_W];
      endfunction

      // Erased message numbers sort below everything else
      function logic [HDR_W-1:0] clamped_key(int unsigned page);
         logic [HDR_W-1:0] hdr;
         hdr = read_hdr(page);
         return (hdr[HDR_W-1:NUM_W] == ERASED_NUM) ? '0 : hdr;
      endfunction

      // Bisection for the newest page; page 1 starts unclamped
      function int unsigned last_written_page();
         int unsigned      bottom;
         int unsigned      top;
         int unsigned      look;
         logic [HDR_W-1:0] bkey;
         logic [HDR_W-1:0] key;
         bottom = 1;
         top    = pages_in_use();
         bkey   = read_hdr(1);
         while (top > bottom + 1) begin
            look = (top + bottom) / 2;
            key  = clamped_key(look);
            if (key < bkey) begin
               top = look;
            end else begin
               bottom = look;
               bkey   = key;
            end
         end
         if (clamped_key(top) > bkey) return top;
         return bottom;
      endfunction

      // Span between the newest message and the one three pages on (or page 1)
      function logic [NUM_W-1:0] message_total();
         int unsigned      lp;
         logic [NUM_W-1:0] last_num;
         logic [NUM_W-1:0] first_num;
         lp = last_written_page();
         if (lp == 1) return '0;
         if (read_num(1) == ERASED_NUM) return '0;
         last_num  = read_num(lp);
         first_num = read_num(lp + 3);
         if (first_num > last_num) first_num = read_num(1);
         if (last_num == first_num) return NUM_W'(1);
         return last_num - first_num + NUM_W'(1);
      endfunction

      // Wrap-aware bisection for the last page of one message
      function logic [NUM_W-1:0] last_page_of(logic [NUM_W-1:0] msg);
         int unsigned      n;
         int unsigned      bottom;
         int unsigned      top;
         int unsigned      look;
         logic [HDR_W-1:0] target;
         n      = pages_in_use();
         bottom = 1;
         target = {msg, ERASED_NUM};
         if (read_num(n) != ERASED_NUM && read_num(1) > msg) begin
            bottom = last_written_page();
            top    = n;
         end else begin
            top = last_written_page();
         end
         while (top > bottom + 1) begin
            look = (top + bottom) / 2;
            if (clamped_key(look) > target) top = look;
            else bottom = look;
         end
         // unclamped compare: an erased page matches message 0xFFFF
         if (read_num(top) == msg) return NUM_W'(top);
         if (read_num(bottom) == msg) return NUM_W'(bottom);
         return ERASED_NUM;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [PIDX_W-1:0] pidx,
                                 logic [NUM_W-1:0] fnum, logic [NUM_W-1:0] fpg,
                                 logic [NUM_W-1:0] msg);
         logic [NUM_W-1:0] answer;
         answer = '0;
         case (op)
            OP_LOAD: begin
               // out-of-store pages are dropped, answer stays 0
               if (pidx != 0 && int'(pidx) <= MAX_PAGES_DEF) hdr_store[pidx - 1'b1] = {fnum, fpg};
            end
            OP_LAST_PAGE: answer = NUM_W'(last_written_page());
            OP_LAST_MSG:  answer = read_num(last_written_page());
            OP_MSG_COUNT: answer = message_total();
            OP_MSG_PAGE:  answer = last_page_of(msg);
            default:      answer = '0;
         endcase
         expected_answers.push_back(answer);
      endfunction

      function void check_answer(logic [NUM_W-1:0] answer);
         logic [NUM_W-1:0] want;
         if (expected_answers.size() == 0) begin
            $error("answer: expected none, actual 0x%04h", answer);
            mismatches++;
            return;
         end
         want = expected_answers.pop_front();
         if (answer !== want) begin
            $error("answer: expected 0x%04h, actual 0x%04h", want, answer);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CFG_W-1:0]    csr_wr_data;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation;
   logic [PIDX_W-1:0]   req_page_index;
   logic [NUM_W-1:0]    req_file_number;
   logic [NUM_W-1:0]    req_file_page;
   logic [NUM_W-1:0]    req_msg_number;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [NUM_W-1:0]    rsp_answer;

   page_search_board    board;
   int unsigned         useful_items = 0;
   bit                  steady = 1'b0;
   bit                  hold_request = 1'b0;
   logic [NUM_W-1:0]    log_first = '0;
   logic [NUM_W-1:0]    log_last = 16'hFFFE;

   circular_log_page_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_page_index  (req_page_index),
      .req_file_number (req_file_number),
      .req_file_page   (req_file_page),
      .req_msg_number  (req_msg_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_answer      (rsp_answer)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mostly back-to-back, some short gaps, the odd long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [OP_W-1:0] query_op();
      return OP_W'($urandom_range(OP_LAST_PAGE, OP_MSG_PAGE));
   endfunction

   // Mostly messages present in the current log, plus neighbours and erased
   function automatic logic [NUM_W-1:0] pick_msg();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return NUM_W'($urandom_range(log_first, log_last));
      if (r == 6) return log_first - 1'b1;
      if (r == 7) return log_last + 1'b1;
      if (r == 8) return ERASED_NUM;
      return NUM_W'($urandom());
   endfunction

   // Offer one item, hold it until taken, then maybe idle
   task automatic send_item(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] pidx,
                            input logic [NUM_W-1:0] fnum, input logic [NUM_W-1:0] fpg,
                            input logic [NUM_W-1:0] msg);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_page_index  <= pidx;
      req_file_number <= fnum;
      req_file_page   <= fpg;
      req_msg_number  <= msg;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (op <= OP_MSG_PAGE && !(op == OP_LOAD && (pidx == 0 || int'(pidx) > MAX_PAGES_DEF)))
         useful_items++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_page(input int unsigned page, input logic [NUM_W-1:0] num,
                            input logic [NUM_W-1:0] pos);
      send_item(OP_LOAD, PIDX_W'(page), num, pos, NUM_W'($urandom()));
   endtask

   task automatic ask(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] msg);
      send_item(op, PIDX_W'($urandom()), NUM_W'($urandom()), NUM_W'($urandom()), msg);
   endtask

   // Stop offering and wait for every owed answer
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_page_count(input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.page_count = value;
   endtask

   // Accepted items and answers, sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_operation, req_page_index, req_file_number,
                               req_file_page, req_msg_number);
         if (rsp_valid && rsp_ready) board.check_answer(rsp_answer);
      end
   end

   // Result side back-pressure, including one long hold on request
   initial begin : receiver
      int unsigned hold;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            hold = pick_gap();
            rsp_ready <= (hold == 0);
            if (hold > 0) hold--;
         end
      end
   end

   // Give up when nothing moves on either side for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL circular_log_page_search");
      $finish;
   end

   initial begin : stimulus
      int unsigned      r;
      int unsigned      cfg;
      int unsigned      n_eff;
      int unsigned      span;
      int unsigned      last_at;
      int unsigned      written;
      int unsigned      base_hi;
      int unsigned      page;
      int unsigned      erase_to;
      bit               wrapped;
      bit               hold_done;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] pos;

      board = new();
      hold_done = 1'b0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_valid       <= 1'b0;
      req_operation   <= '0;
      req_page_index  <= '0;
      req_file_number <= '0;
      req_file_page   <= '0;
      req_msg_number  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Erased store at reset size; erased pages match message 0xFFFF
      ask(OP_LAST_PAGE, NUM_W'($urandom()));
      ask(OP_LAST_MSG, NUM_W'($urandom()));
      ask(OP_MSG_COUNT, NUM_W'($urandom()));
      ask(OP_MSG_PAGE, ERASED_NUM);
      ask(OP_MSG_PAGE, '0);
      for (int unsigned op = OP_UNUSED_5; op <= OP_UNUSED_7; op++)
         ask(OP_W'(op), NUM_W'($urandom()));

      // Loads outside the store are dropped
      send_item(OP_LOAD, '0, '1, '1, '1);
      send_item(OP_LOAD, PIDX_W'(MAX_PAGES_DEF + 1), '0, '0, '0);
      send_item(OP_LOAD, '1, 16'h0000, 16'hFFFF, 16'h5555);

      // Short log from page 1, plus a large key at the top page
      load_page(1, 16'd0, 16'd0);
      load_page(2, 16'd0, 16'd1);
      load_page(3, 16'd1, 16'd0);
      load_page(MAX_PAGES_DEF, 16'hFFFE, 16'hFFFF);
      ask(OP_LAST_PAGE, '0);
      ask(OP_LAST_MSG, '0);
      ask(OP_MSG_COUNT, '0);
      ask(OP_MSG_PAGE, 16'd1);
      ask(OP_MSG_PAGE, 16'hFFFE);

      // Page count 0 behaves as a single page
      drain();
      write_page_count(0);
      ask(OP_LAST_PAGE, '1);
      ask(OP_MSG_COUNT, '1);
      ask(OP_MSG_PAGE, '0);

      // Count above the store depth clamps to the full store
      drain();
      write_page_count(CFG_MAX);
      ask(OP_LAST_PAGE, '0);
      ask(OP_MSG_PAGE, 16'hFFFE);

      // Random phases: new page count, a log (or noise), then queries
      while (useful_items < ITEM_TARGET) begin
         drain();
         steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 60) cfg = $urandom_range(2, 40);
         else if (r < 75) cfg = $urandom_range(41, 300);
         else if (r < 82) cfg = 1;
         else if (r < 86) cfg = 0;
         else if (r < 94) cfg = MAX_PAGES_DEF;
         else cfg = $urandom_range(MAX_PAGES_DEF + 1, CFG_MAX);
         write_page_count(cfg);
         n_eff = board.pages_in_use();

         // once: stall the result side while the log is written
         if (!hold_done) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end

         if ($urandom_range(0, 4) != 0) begin
            // Circular log, oldest entry first; newest lands on last_at
            span     = (n_eff <= SMALL_LOG) ? n_eff : $urandom_range(1, 40);
            wrapped  = (n_eff <= SMALL_LOG) && ($urandom_range(0, 1) == 1);
            last_at  = $urandom_range(1, span);
            written  = wrapped ? span : last_at;
            base_hi  = 32'hFFFE - 2 * written;
            num      = ($urandom_range(0, 4) == 0) ? NUM_W'(base_hi)
                                                   : NUM_W'($urandom_range(0, base_hi));
            pos      = ($urandom_range(0, 1) == 0) ? '0 : NUM_W'($urandom_range(0, 200));
            log_first = num;
            log_last  = NUM_W'(32'(num) + 2 * written);
            for (int unsigned j = 0; j < written; j++) begin
               page = wrapped ? ((last_at + j) % span) + 1 : j + 1;
               load_page(page, num, pos);
               if ($urandom_range(0, 2) == 0) begin
                  num = num + NUM_W'($urandom_range(1, 2));
                  pos = '0;
               end else begin
                  pos = pos + 1'b1;
               end
               // queries against the partly written log
               if ($urandom_range(0, 9) == 0) ask(query_op(), pick_msg());
            end
            if (!wrapped) begin
               erase_to = (n_eff <= SMALL_LOG) ? n_eff
                        : ((last_at + 4 < n_eff) ? last_at + 4 : n_eff);
               for (page = last_at + 1; page <= erase_to; page++)
                  load_page(page, ERASED_NUM, '1);
            end
            // erased first page, or one corrupted header
            if ($urandom_range(0, 7) == 0) load_page(1, ERASED_NUM, '1);
            if ($urandom_range(0, 7) == 0)
               load_page($urandom_range(1, n_eff), NUM_W'($urandom()), NUM_W'($urandom()));
         end else begin
            // Scattered headers, some outside the log or the store
            log_first = '0;
            log_last  = 16'hFFFE;
            repeat ($urandom_range(10, 40)) begin
               r = $urandom_range(0, 19);
               if (r < 14) page = $urandom_range(1, n_eff + 2);
               else if (r < 17) page = $urandom_range(0, CFG_MAX);
               else page = 1;
               num = ($urandom_range(0, 4) == 0) ? ERASED_NUM : NUM_W'($urandom());
               send_item(OP_LOAD, PIDX_W'(page), num, NUM_W'($urandom()),
                         NUM_W'($urandom()));
            end
         end

         // Queries, with the odd no-op code and stray load
         repeat ($urandom_range(6, 20)) begin
            r = $urandom_range(0, 19);
            if (r == 0) ask(OP_W'($urandom_range(OP_UNUSED_5, OP_UNUSED_7)), pick_msg());
            else if (r == 1)
               load_page($urandom_range(1, n_eff), NUM_W'($urandom()), NUM_W'($urandom()));
            else ask(query_op(), pick_msg());
         end
      end

      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASS circular_log_page_search");
      else
         $display("FAIL circular_log_page_search");
      $finish;
   end

endmodule
